// ===== design/rcpc_pkg.sv =====
// Shared types, constants and the pin-to-slot map for the RC PWM pulse capture block.
// No dependencies; used by rcpc_edge_eval and rc_pwm_pulse_capture.
`default_nettype none

package rcpc_pkg;

    localparam int NUM_PINS   = 8;
    localparam int PIN_IDX_W  = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    localparam int LEVELS_W   = 8;
    localparam int TIME_W     = 16;
    localparam int SLOT_W     = 3;
    localparam int PWIDTH_W   = 12;
    localparam int MAIN_SLOTS = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_ENABLE    = 3'd4;

    localparam logic [LEVELS_W-1:0]   RST_PIN_ENABLE   = 8'd255;
    localparam logic [TIME_W-1:0]     RST_MIN_WIDTH    = 16'd900;
    localparam logic [TIME_W-1:0]     RST_MAX_WIDTH    = 16'd2200;
    localparam logic [TIME_W-1:0]     RST_FS_THRESHOLD = 16'd985;

    localparam logic [PWIDTH_W-1:0]   PWIDTH_SAT       = 12'd4095;
    localparam logic [MAIN_SLOTS-1:0] MAIN_MASK_FULL   = 4'hF;

    typedef struct packed {
        logic [LEVELS_W-1:0] pin_enable;
        logic [TIME_W-1:0]   min_width;
        logic [TIME_W-1:0]   max_width;
        logic [TIME_W-1:0]   fs_threshold;
        logic                fs_enable;
    } cfg_t;

    typedef struct packed {
        logic [NUM_PINS-1:0]               hit;
        logic [NUM_PINS-1:0][PWIDTH_W-1:0] width;
        logic [NUM_PINS-1:0]               rise_load;
        logic                              credit;
        logic [MAIN_SLOTS-1:0]             good_next;
    } eval_t;

    // Fixed receiver wiring: pins 0..7 land on slots 2,4,5,6,7,0,1,3
    function automatic logic [SLOT_W-1:0] slot_of_pin(input logic [2:0] pin);
        logic [SLOT_W-1:0] slot;
        case (pin)
            3'd0:    slot = 3'd2;
            3'd1:    slot = 3'd4;
            3'd2:    slot = 3'd5;
            3'd3:    slot = 3'd6;
            3'd4:    slot = 3'd7;
            3'd5:    slot = 3'd0;
            3'd6:    slot = 3'd1;
            3'd7:    slot = 3'd3;
            default: slot = 3'd0;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

// ===== design/rcpc_edge_eval.sv =====
// Edge evaluation for one port change event: widths, limit checks, good-mask update.
// Depends on rcpc_pkg.
`default_nettype none

module rcpc_edge_eval
    import rcpc_pkg::*;
(
    input  wire logic [LEVELS_W-1:0] levels,
    input  wire logic [TIME_W-1:0]   time_us,
    input  wire logic [LEVELS_W-1:0] prev_levels,
    input  wire cfg_t                cfg,
    input  wire logic [MAIN_SLOTS-1:0] good_mask,
    input  wire logic [TIME_W-1:0]   rise_time [NUM_PINS],
    output eval_t                    result
);

    logic [LEVELS_W-1:0]   changed;
    logic [TIME_W-1:0]     width_full [NUM_PINS];
    logic [NUM_PINS-1:0]   in_limits;
    logic [MAIN_SLOTS-1:0] good_set;
    logic [MAIN_SLOTS-1:0] good_or;
    logic [SLOT_W-1:0]     slot;

    assign changed = (levels ^ prev_levels) & cfg.pin_enable;

    always_comb begin
        good_set = '0;
        result.hit       = '0;
        result.width     = '0;
        result.rise_load = '0;
        slot = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
            width_full[i] = time_us - rise_time[i];
            in_limits[i]  = (width_full[i] > cfg.min_width) &&
                            (width_full[i] < cfg.max_width);
            result.rise_load[i] = changed[i] & levels[i];
            result.hit[i]       = changed[i] & ~levels[i] & in_limits[i];
            result.width[i]     = (width_full[i] > TIME_W'(PWIDTH_SAT)) ?
                                  PWIDTH_SAT : width_full[i][PWIDTH_W-1:0];
            slot = slot_of_pin(3'(i));
            // Main slots score on the unsaturated width
            if (result.hit[i] && (slot < SLOT_W'(MAIN_SLOTS)) &&
                (width_full[i] > cfg.fs_threshold)) begin
                good_set[slot[1:0]] = 1'b1;
            end
        end

        good_or = good_mask | good_set;
        result.credit    = 1'b0;
        result.good_next = good_mask;
        if (cfg.fs_enable) begin
            result.good_next = good_or;
            if ((|result.hit) && (good_or == MAIN_MASK_FULL)) begin
                result.credit    = 1'b1;
                result.good_next = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/rc_pwm_pulse_capture.sv =====
// Top level of the multichannel RC PWM pulse width capture block.
// Depends on rcpc_pkg and rcpc_edge_eval.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  s_      | in        | s_tvalid / s_tready    | s_tdata: pin_levels, time_us
//  m_      | out       | m_tvalid / m_tready    | m_tdata: rc_slot, pulse_width;
//          |           |                        | m_tuser: failsafe_credit; m_tlast: last
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An event hands its n results (0..8) to the result stage, which emits one transaction per
// cycle unless m_tready is low; events with at most one result then stream at one per cycle.
// m_tvalid for the first result rises once the input transaction has passed the input
// register, event buffer and output register. Reset loads the register defaults and clears
// levels, rise times and mask. A stalled m_ side holds the output register; the event buffer
// then fills and s_tready drops until it drains. cfg_ready is always high.
`default_nettype none

module rc_pwm_pulse_capture
    import rcpc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] pin_levels, [23:8] time_us

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [2:0] rc_slot, [14:3] pulse_width, [15] 0
    output logic                       m_tuser,   // [0] failsafe_credit
    output logic                       m_tlast,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    cfg_t cfg_reg;

    // Input register
    logic                  a_valid_reg;
    logic [LEVELS_W-1:0]   a_levels_reg;
    logic [TIME_W-1:0]     a_time_reg;

    // Capture state
    logic [LEVELS_W-1:0]   prev_levels_reg;
    logic [TIME_W-1:0]     rise_reg [NUM_PINS];
    logic [MAIN_SLOTS-1:0] good_reg;

    // Event buffer: pending results of one evaluated event
    logic [NUM_PINS-1:0]               b_mask_reg;
    logic [NUM_PINS-1:0][PWIDTH_W-1:0] b_width_reg;
    logic                              b_credit_reg;

    // Output register
    logic                  o_valid_reg;
    logic [SLOT_W-1:0]     o_slot_reg;
    logic [PWIDTH_W-1:0]   o_width_reg;
    logic                  o_credit_reg;
    logic                  o_last_reg;

    eval_t                 eval;
    logic                  o_free;
    logic                  b_pop;
    logic                  b_load_ok;
    logic                  a_move;
    logic                  s_fire;
    logic [NUM_PINS-1:0]   b_rest;
    logic [PIN_IDX_W-1:0]  b_sel;

    rcpc_edge_eval u_eval (
        .levels      (a_levels_reg),
        .time_us     (a_time_reg),
        .prev_levels (prev_levels_reg),
        .cfg         (cfg_reg),
        .good_mask   (good_reg),
        .rise_time   (rise_reg),
        .result      (eval)
    );

    // Lowest pending pin goes out first
    always_comb begin
        b_sel = '0;
        for (int i = NUM_PINS - 1; i >= 0; i--) begin
            if (b_mask_reg[i]) begin
                b_sel = PIN_IDX_W'(i);
            end
        end
    end

    assign b_rest    = b_mask_reg & (b_mask_reg - NUM_PINS'(1));
    assign o_free    = ~o_valid_reg | m_tready;
    assign b_pop     = (|b_mask_reg) & o_free;
    // Buffer can take a new event once its last pending result leaves
    assign b_load_ok = ~(|b_mask_reg) | (b_pop & ~(|b_rest));
    assign a_move    = a_valid_reg & b_load_ok;
    assign s_tready  = ~a_valid_reg | a_move;
    assign s_fire    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {1'b0, o_width_reg, o_slot_reg};
    assign m_tuser  = o_credit_reg;
    assign m_tlast  = o_last_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pin_enable   <= RST_PIN_ENABLE;
            cfg_reg.min_width    <= RST_MIN_WIDTH;
            cfg_reg.max_width    <= RST_MAX_WIDTH;
            cfg_reg.fs_threshold <= RST_FS_THRESHOLD;
            cfg_reg.fs_enable    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PIN_ENABLE:   cfg_reg.pin_enable   <= cfg_data[LEVELS_W-1:0];
                CFG_MIN_WIDTH:    cfg_reg.min_width    <= cfg_data;
                CFG_MAX_WIDTH:    cfg_reg.max_width    <= cfg_data;
                CFG_FS_THRESHOLD: cfg_reg.fs_threshold <= cfg_data;
                CFG_FS_ENABLE:    cfg_reg.fs_enable    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold until the event buffer can take the evaluated event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_fire) begin
            a_valid_reg <= 1'b1;
        end else if (a_move) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_levels_reg <= s_tdata[LEVELS_W-1:0];
            a_time_reg   <= s_tdata[LEVELS_W +: TIME_W];
        end
    end

    // Capture state advances once per event, in event order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_levels_reg <= '0;
            good_reg        <= '0;
            for (int i = 0; i < NUM_PINS; i++) begin
                rise_reg[i] <= '0;
            end
        end else if (a_move) begin
            prev_levels_reg <= a_levels_reg;
            good_reg        <= eval.good_next;
            for (int i = 0; i < NUM_PINS; i++) begin
                if (eval.rise_load[i]) begin
                    rise_reg[i] <= a_time_reg;
                end
            end
        end
    end

    // Event buffer: load on a_move, otherwise drop one pending result per pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_mask_reg <= '0;
        end else if (a_move) begin
            b_mask_reg <= eval.hit;
        end else if (b_pop) begin
            b_mask_reg <= b_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_width_reg  <= eval.width;
            b_credit_reg <= eval.credit;
        end
    end

    // Output register: refill whenever it empties or is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_free) begin
            o_valid_reg <= |b_mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_pop) begin
            o_slot_reg   <= slot_of_pin(3'(b_sel));
            o_width_reg  <= b_width_reg[b_sel];
            o_last_reg   <= ~(|b_rest);
            o_credit_reg <= b_credit_reg & ~(|b_rest);
        end
    end

endmodule

`default_nettype wire
